[rtl/macd_pkg.sv]
`timescale 1ns / 1ps
// macd_pkg: shared types, constants and helpers for the macd indicator
// used by the channel interfaces, the sequencer, the ema unit and the top level

package macd_pkg;

    localparam int PRICE_W          = 32;
    localparam int CFG_DATA_W       = 17;
    localparam int CFG_ADDR_W       = 2;
    localparam int COEFF_FRAC_DEF   = 16;

    localparam logic [CFG_DATA_W-1:0] FAST_ALPHA_RST   = 17'd10082;
    localparam logic [CFG_DATA_W-1:0] SLOW_ALPHA_RST   = 17'd4855;
    localparam logic [CFG_DATA_W-1:0] SIGNAL_ALPHA_RST = 17'd13107;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FAST_ALPHA   = 2'd0,
        REG_SLOW_ALPHA   = 2'd1,
        REG_SIGNAL_ALPHA = 2'd2,
        REG_UNUSED       = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_FAST,
        ST_MUL_SLOW,
        ST_ADD_SLOW,
        ST_LINE,
        ST_MUL_SIG,
        ST_ADD_SIG,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        OP_FAST,
        OP_SLOW,
        OP_SIG
    } op_sel_t;

    typedef struct packed {
        logic    sample_ready;
        logic    mul_en;
        op_sel_t op_sel;
        logic    fast_we;
        logic    slow_we;
        logic    line_we;
        logic    sig_we;
        logic    out_load;
    } ctrl_t;

    // clamp a 33-bit signed value into 32 bits
    function automatic logic signed [PRICE_W-1:0] sat32(input logic signed [PRICE_W:0] v);
        logic signed [PRICE_W-1:0] r;
        if (v[PRICE_W] != v[PRICE_W-1])
        begin
            r = v[PRICE_W] ? {1'b1, {(PRICE_W-1){1'b0}}} : {1'b0, {(PRICE_W-1){1'b1}}};
        end
        else
        begin
            r = v[PRICE_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/macd_sample_if.sv]
`timescale 1ns / 1ps
// macd_sample_if: input channel carrying one price word
// depends on macd_pkg for field widths

interface macd_sample_if;
    import macd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [PRICE_W-1:0]  price;
    logic                       restart;

    modport source (output valid, output price, output restart, input ready);
    modport sink   (input valid, input price, input restart, output ready);
endinterface

[rtl/macd_result_if.sv]
`timescale 1ns / 1ps
// macd_result_if: output channel carrying the macd, signal and histogram word
// depends on macd_pkg for field widths

interface macd_result_if;
    import macd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [PRICE_W-1:0]  macd_line;
    logic signed [PRICE_W-1:0]  signal_line;
    logic signed [PRICE_W-1:0]  histogram;

    modport source (output valid, output macd_line, output signal_line, output histogram,
                    input ready);
    modport sink   (input valid, input macd_line, input signal_line, input histogram,
                    output ready);
endinterface

[rtl/macd_ema_unit.sv]
`timescale 1ns / 1ps
// macd_ema_unit: shared multiply and shift-add unit for one ema step
// depends on macd_pkg; product registered, update formed from the registers

module macd_ema_unit #(
    parameter int COEFF_FRACTION_BITS = macd_pkg::COEFF_FRAC_DEF
) (
    input  logic                                   clk,
    input  logic                                   mul_en,
    input  logic signed [macd_pkg::PRICE_W-1:0]    op_x,
    input  logic signed [macd_pkg::PRICE_W-1:0]    op_avg,
    input  logic [COEFF_FRACTION_BITS:0]           alpha,
    output logic signed [macd_pkg::PRICE_W-1:0]    avg_new
);
    import macd_pkg::*;

    localparam int DIFF_W = PRICE_W + 1;
    localparam int PROD_W = DIFF_W + COEFF_FRACTION_BITS + 2;

    logic signed [DIFF_W-1:0]  diff;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PRICE_W-1:0] avg_reg;
    logic signed [PROD_W-1:0]  shifted;
    logic [PRICE_W+1:0]        sum;

    assign diff = {op_x[PRICE_W-1], op_x} - {op_avg[PRICE_W-1], op_avg};
    assign prod = PROD_W'(diff) * $signed({1'b0, alpha});

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= prod;
            avg_reg  <= op_avg;
        end
    end

    // arithmetic shift floors; the step never exceeds the 33-bit difference
    assign shifted = prod_reg >>> COEFF_FRACTION_BITS;
    assign sum     = {{2{avg_reg[PRICE_W-1]}}, avg_reg} + shifted[PRICE_W+1:0];
    assign avg_new = sum[PRICE_W-1:0];

endmodule

[rtl/macd_ctrl.sv]
`timescale 1ns / 1ps
// macd_ctrl: sequencer stepping the shared ema unit through fast, slow and signal
// depends on macd_pkg for state and control types

module macd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    input  logic                seed,
    input  logic                out_free,
    output macd_pkg::ctrl_t     ctrl
);
    import macd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = seed ? ST_OUT : ST_MUL_FAST;
                end
            end
            ST_MUL_FAST: state_next = ST_MUL_SLOW;
            ST_MUL_SLOW: state_next = ST_ADD_SLOW;
            ST_ADD_SLOW: state_next = ST_LINE;
            ST_LINE:     state_next = ST_MUL_SIG;
            ST_MUL_SIG:  state_next = ST_ADD_SIG;
            ST_ADD_SIG:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        ctrl.op_sel = OP_FAST;
        unique case (state_reg)
            ST_IDLE:     ctrl.sample_ready = 1'b1;
            ST_MUL_FAST:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.op_sel = OP_FAST;
            end
            ST_MUL_SLOW:
            begin
                ctrl.fast_we = 1'b1;
                ctrl.mul_en  = 1'b1;
                ctrl.op_sel  = OP_SLOW;
            end
            ST_ADD_SLOW: ctrl.slow_we = 1'b1;
            ST_LINE:     ctrl.line_we = 1'b1;
            ST_MUL_SIG:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.op_sel = OP_SIG;
            end
            ST_ADD_SIG:  ctrl.sig_we = 1'b1;
            ST_OUT:      ctrl.out_load = out_free;
            default:     ctrl = '0;
        endcase
    end

endmodule

[rtl/macd_indicator.sv]
`timescale 1ns / 1ps
// macd_indicator: fast, slow and signal ema over a price stream, one result word per sample
// sequence: each word steps through mul fast, mul slow, add slow, line, mul sig, add sig,
// out; a series start word goes straight to out; one shared multiplier serves all three
// emas in turn, so a new sample is taken only once the sequencer is back in idle
// reset: averages and primed flag clear, alpha registers load their default periods
// depends on macd_pkg, macd_sample_if, macd_result_if, macd_ctrl, macd_ema_unit

module macd_indicator #(
    parameter int COEFF_FRACTION_BITS = macd_pkg::COEFF_FRAC_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    macd_sample_if.sink                         sample,
    macd_result_if.source                       result,
    input  logic                                cfg_en,
    input  logic [macd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [macd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import macd_pkg::*;

    localparam int ALPHA_W = COEFF_FRACTION_BITS + 1;
    localparam int CMP_W   = (ALPHA_W > CFG_DATA_W) ? ALPHA_W : CFG_DATA_W;
    localparam logic [CMP_W-1:0] ALPHA_ONE = CMP_W'(1) << COEFF_FRACTION_BITS;

    logic [CFG_DATA_W-1:0]      fast_alpha_reg;
    logic [CFG_DATA_W-1:0]      slow_alpha_reg;
    logic [CFG_DATA_W-1:0]      signal_alpha_reg;

    logic signed [PRICE_W-1:0]  x_reg;
    logic signed [PRICE_W-1:0]  fast_reg;
    logic signed [PRICE_W-1:0]  slow_reg;
    logic signed [PRICE_W-1:0]  line_reg;
    logic signed [PRICE_W-1:0]  sig_reg;
    logic                       primed_reg;

    logic                       out_valid_reg;
    logic signed [PRICE_W-1:0]  macd_line_reg;
    logic signed [PRICE_W-1:0]  signal_line_reg;
    logic signed [PRICE_W-1:0]  histogram_reg;

    ctrl_t                      ctrl;
    logic                       seed;
    logic                       accept;
    logic                       out_free;
    logic signed [PRICE_W-1:0]  op_x;
    logic signed [PRICE_W-1:0]  op_avg;
    logic [CFG_DATA_W-1:0]      alpha_raw;
    logic [CMP_W-1:0]           alpha_ext;
    logic [ALPHA_W-1:0]         alpha;
    logic signed [PRICE_W-1:0]  avg_new;

    assign seed     = sample.restart || !primed_reg;
    assign accept   = sample.valid && ctrl.sample_ready;
    assign out_free = !out_valid_reg || result.ready;

    assign sample.ready       = ctrl.sample_ready;
    assign result.valid       = out_valid_reg;
    assign result.macd_line   = macd_line_reg;
    assign result.signal_line = signal_line_reg;
    assign result.histogram   = histogram_reg;

    macd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .seed         (seed),
        .out_free     (out_free),
        .ctrl         (ctrl)
    );

    // operand select for the shared unit
    always_comb
    begin
        case (ctrl.op_sel)
            OP_SLOW:
            begin
                op_x      = x_reg;
                op_avg    = slow_reg;
                alpha_raw = slow_alpha_reg;
            end
            OP_SIG:
            begin
                op_x      = line_reg;
                op_avg    = sig_reg;
                alpha_raw = signal_alpha_reg;
            end
            default:
            begin
                op_x      = x_reg;
                op_avg    = fast_reg;
                alpha_raw = fast_alpha_reg;
            end
        endcase
    end

    // alpha above one is clamped to exactly one
    assign alpha_ext = CMP_W'(alpha_raw);
    assign alpha     = (alpha_ext > ALPHA_ONE) ? ALPHA_ONE[ALPHA_W-1:0] : alpha_ext[ALPHA_W-1:0];

    macd_ema_unit #(
        .COEFF_FRACTION_BITS (COEFF_FRACTION_BITS)
    ) u_ema (
        .clk     (clk),
        .mul_en  (ctrl.mul_en),
        .op_x    (op_x),
        .op_avg  (op_avg),
        .alpha   (alpha),
        .avg_new (avg_new)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_alpha_reg   <= FAST_ALPHA_RST;
            slow_alpha_reg   <= SLOW_ALPHA_RST;
            signal_alpha_reg <= SIGNAL_ALPHA_RST;
        end
        else if (cfg_en)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_FAST_ALPHA:   fast_alpha_reg   <= cfg_data;
                REG_SLOW_ALPHA:   slow_alpha_reg   <= cfg_data;
                REG_SIGNAL_ALPHA: signal_alpha_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_reg   <= '0;
            slow_reg   <= '0;
            sig_reg    <= '0;
            line_reg   <= '0;
            primed_reg <= 1'b0;
        end
        else
        begin
            if (accept && seed)
            begin
                fast_reg   <= sample.price;
                slow_reg   <= sample.price;
                sig_reg    <= '0;
                line_reg   <= '0;
                primed_reg <= 1'b1;
            end
            if (ctrl.fast_we)
            begin
                fast_reg <= avg_new;
            end
            if (ctrl.slow_we)
            begin
                slow_reg <= avg_new;
            end
            if (ctrl.line_we)
            begin
                line_reg <= sat32({fast_reg[PRICE_W-1], fast_reg}
                                  - {slow_reg[PRICE_W-1], slow_reg});
            end
            if (ctrl.sig_we)
            begin
                sig_reg <= avg_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= sample.price;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            macd_line_reg   <= line_reg;
            signal_line_reg <= sig_reg;
            histogram_reg   <= sat32({line_reg[PRICE_W-1], line_reg}
                                     - {sig_reg[PRICE_W-1], sig_reg});
        end
    end

endmodule
